// File: src/alarm_panel_controller_unit_defines.svh
// Assertion macros shared by the alarm panel controller RTL.
`ifndef ALARM_PANEL_CONTROLLER_UNIT_DEFINES_SVH
`define ALARM_PANEL_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define APC_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alarm panel check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define APC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alarm panel sequencing check failed");

`endif

// File: src/apc_pkg.sv
// Types, constants and the alarm blink helper for the alarm panel controller.
package apc_pkg;

    typedef logic [1:0]        t_mode;
    typedef logic [7:0]        t_count;
    typedef logic signed [7:0] t_accel;
    typedef logic [1:0]        t_cfg_index;

    // Mode codes.
    localparam t_mode MODE_DISARMED = 2'd0;
    localparam t_mode MODE_ARMED    = 2'd1;
    localparam t_mode MODE_ALARM    = 2'd2;
    localparam t_mode MODE_UNUSED   = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_index CFG_TILT_LIMIT    = 2'd0;
    localparam t_cfg_index CFG_GRAVITY_FLOOR = 2'd1;

    // Configuration reset values.
    localparam t_accel TILT_LIMIT_RESET    = 8'sd16;
    localparam t_accel GRAVITY_FLOOR_RESET = 8'sd48;

    // Blink timing, in ticks.
    localparam t_count DIS_ONE_ON_LAST  = 8'd27;
    localparam t_count DIS_ONE_OFF_LAST = 8'd49;
    localparam t_count HALF_PERIOD      = 8'd25;
    localparam t_count FULL_PERIOD      = 8'd50;
    localparam t_count ALARM_ON_LAST    = 8'd5;
    localparam t_count ALARM_PERIOD     = 8'd10;

    typedef struct packed {
        t_count count;
        logic   led;
    } t_blink;

    // One alarm-mode blink step for a single LED.
    function automatic t_blink alarm_blink(input t_count count, input logic led,
                                           input logic trig);
        t_blink res;
        res.count = count;
        res.led   = led;
        if (trig) begin
            res.count = count + 8'd1;
            if (res.count <= ALARM_ON_LAST) begin
                res.led = 1'b1;
            end else begin
                res.led = 1'b0;
                if (res.count >= ALARM_PERIOD) begin
                    res.count = '0;
                end
            end
        end else begin
            res.count = '0;
        end
        return res;
    endfunction

endpackage

// File: src/alarm_panel_controller_unit.sv
// Alarm panel controller top level: mode machine, LED blinking and tamper check.
//
// Usage: one input word per 10 ms tick carries the key events, the two touch
// pads and three signed accelerometer bytes; one result word per tick gives
// the LED levels, the tone enable, the mode after the tick and a tamper flag.
// Input and result channels use valid/ready. A separate configuration channel
// writes the tilt limit (index 0) and the gravity floor (index 1); writes to
// other indexes are dropped, and it is always ready.
// An accepted word is captured in the input register; its result is then
// loaded into the result register once the result stage can advance, and
// o_valid rises with it.
// Throughput: one word per cycle when the receiver does not stall; the input
// register and the result register form a two-deep pipeline, and the per-tick
// state update is a single pass of compares and 8-bit increments between them.
// Reset clears both stages, sets disarmed mode with armed as the previous
// mode (so the first tick runs the disarm entry), zeroes counters, triggers,
// LEDs and tone, and restores the threshold defaults.
// When the receiver stalls, the result holds, the input register still takes
// one more word, and o_ready then drops until the result is taken.
`include "alarm_panel_controller_unit_defines.svh"

module alarm_panel_controller_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_arm_key,
    input  logic                 i_disarm_key,
    input  logic                 i_pad_one,
    input  logic                 i_pad_two,
    input  apc_pkg::t_accel      i_accel_x,
    input  apc_pkg::t_accel      i_accel_y,
    input  apc_pkg::t_accel      i_accel_z,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_led_one,
    output logic                 o_led_two,
    output logic                 o_tone_on,
    output apc_pkg::t_mode       o_mode,
    output logic                 o_tamper,
    // Configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  apc_pkg::t_cfg_index  i_cfg_index,
    input  apc_pkg::t_accel      i_cfg_data
);

    import apc_pkg::*;

    // Configuration registers.
    t_accel r_tilt_limit;
    t_accel r_gravity_floor;

    // Input stage.
    logic   r_in_valid;
    logic   r_arm, r_disarm, r_pad_one, r_pad_two;
    t_accel r_ax, r_ay, r_az;

    // Controller state.
    t_mode  r_cur_mode, n_cur_mode;
    t_mode  r_prev_mode, n_prev_mode;
    t_count r_cnt_one, n_cnt_one;
    t_count r_cnt_two, n_cnt_two;
    logic   r_trig_one, n_trig_one;
    logic   r_trig_two, n_trig_two;
    logic   r_led_one, n_led_one;
    logic   r_led_two, n_led_two;
    logic   r_tone, n_tone;

    // Result stage.
    logic   r_out_valid;
    logic   r_out_tamper, n_out_tamper;

    logic   w_out_adv;
    logic   w_fire;
    logic   w_in_take;

    // Pipeline handshake.
    assign w_out_adv   = !r_out_valid || i_ready;
    assign o_ready     = !r_in_valid || w_out_adv;
    assign w_in_take   = i_valid && o_ready;
    assign w_fire      = r_in_valid && w_out_adv;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_limit    <= TILT_LIMIT_RESET;
            r_gravity_floor <= GRAVITY_FLOOR_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TILT_LIMIT) begin
                r_tilt_limit <= i_cfg_data;
            end else if (i_cfg_index == CFG_GRAVITY_FLOOR) begin
                r_gravity_floor <= i_cfg_data;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_arm     <= i_arm_key;
            r_disarm  <= i_disarm_key;
            r_pad_one <= i_pad_one;
            r_pad_two <= i_pad_two;
            r_ax      <= i_accel_x;
            r_ay      <= i_accel_y;
            r_az      <= i_accel_z;
        end
    end

    // One tick: mode logic with entry actions, then LED logic, then tamper.
    always_comb begin
        t_blink b_one;
        t_blink b_two;
        n_cur_mode  = r_cur_mode;
        n_prev_mode = r_prev_mode;
        n_cnt_one   = r_cnt_one;
        n_cnt_two   = r_cnt_two;
        n_trig_one  = r_trig_one;
        n_trig_two  = r_trig_two;
        n_led_one   = r_led_one;
        n_led_two   = r_led_two;
        n_tone      = r_tone;

        // Entry actions run one tick after a mode change, then the keys act.
        unique case (r_cur_mode)
            MODE_DISARMED: begin
                if (r_prev_mode != MODE_DISARMED) begin
                    n_led_one   = 1'b0;
                    n_led_two   = 1'b0;
                    n_trig_one  = 1'b0;
                    n_trig_two  = 1'b0;
                    n_cnt_one   = '0;
                    n_cnt_two   = '0;
                    n_prev_mode = MODE_DISARMED;
                    n_tone      = 1'b0;
                end
                if (r_arm) begin
                    n_cur_mode = MODE_ARMED;
                end
            end
            MODE_ARMED: begin
                if (r_prev_mode != MODE_ARMED) begin
                    n_cnt_one   = '0;
                    n_prev_mode = MODE_ARMED;
                end
                if (r_disarm) begin
                    n_cur_mode = MODE_DISARMED;
                end
            end
            MODE_ALARM: begin
                if (r_prev_mode != MODE_ALARM) begin
                    n_led_one   = 1'b0;
                    n_led_two   = 1'b0;
                    n_cnt_one   = '0;
                    n_cnt_two   = '0;
                    n_prev_mode = MODE_ALARM;
                    n_tone      = 1'b1;
                end
                if (r_disarm) begin
                    n_cur_mode = MODE_DISARMED;
                end
            end
            default: begin
                n_cur_mode = MODE_DISARMED;
            end
        endcase

        // LED logic works on the mode left by the step above.
        b_one = alarm_blink(n_cnt_one, n_led_one, n_trig_one | r_pad_one);
        b_two = alarm_blink(n_cnt_two, n_led_two, n_trig_two | r_pad_two);
        unique case (n_cur_mode)
            MODE_DISARMED: begin
                n_cnt_one = n_cnt_one + 8'd1;
                n_cnt_two = n_cnt_two + 8'd1;
                if (r_pad_one) begin
                    if (n_cnt_one <= DIS_ONE_ON_LAST) begin
                        n_led_one = 1'b1;
                    end else if (n_cnt_one <= DIS_ONE_OFF_LAST) begin
                        n_led_one = 1'b0;
                    end else begin
                        n_cnt_one = '0;
                    end
                end else begin
                    n_led_one = 1'b0;
                end
                if (r_pad_two) begin
                    if (n_cnt_two <= HALF_PERIOD) begin
                        n_led_two = 1'b1;
                    end else begin
                        n_led_two = 1'b0;
                        if (n_cnt_two >= FULL_PERIOD) begin
                            n_cnt_two = '0;
                        end
                    end
                end else begin
                    n_led_two = 1'b0;
                end
            end
            MODE_ARMED: begin
                if (r_pad_one) begin
                    n_trig_one = 1'b1;
                    n_cur_mode = MODE_ALARM;
                end
                if (r_pad_two) begin
                    n_trig_two = 1'b1;
                    n_cur_mode = MODE_ALARM;
                end
                n_cnt_one = n_cnt_one + 8'd1;
                if (n_cnt_one <= HALF_PERIOD) begin
                    n_led_one = 1'b1;
                    n_led_two = 1'b0;
                end else begin
                    n_led_two = 1'b1;
                    n_led_one = 1'b0;
                    if (n_cnt_one >= FULL_PERIOD) begin
                        n_cnt_one = '0;
                    end
                end
            end
            MODE_ALARM: begin
                n_trig_one = n_trig_one | r_pad_one;
                n_trig_two = n_trig_two | r_pad_two;
                n_cnt_one  = b_one.count;
                n_led_one  = b_one.led;
                n_cnt_two  = b_two.count;
                n_led_two  = b_two.led;
            end
            default: begin
                n_cur_mode = MODE_DISARMED;
            end
        endcase

        // Tamper flag from the accelerometer thresholds.
        n_out_tamper = (r_ax >= r_tilt_limit) || (r_ay >= r_tilt_limit)
                    || (r_az <= r_gravity_floor);
    end

    // State update and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cur_mode  <= MODE_DISARMED;
            r_prev_mode <= MODE_ARMED;
            r_cnt_one   <= '0;
            r_cnt_two   <= '0;
            r_trig_one  <= 1'b0;
            r_trig_two  <= 1'b0;
            r_led_one   <= 1'b0;
            r_led_two   <= 1'b0;
            r_tone      <= 1'b0;
        end else begin
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_cur_mode  <= n_cur_mode;
                r_prev_mode <= n_prev_mode;
                r_cnt_one   <= n_cnt_one;
                r_cnt_two   <= n_cnt_two;
                r_trig_one  <= n_trig_one;
                r_trig_two  <= n_trig_two;
                r_led_one   <= n_led_one;
                r_led_two   <= n_led_two;
                r_tone      <= n_tone;
            end
        end
    end

    // Result payload that is not already held in the state registers.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_tamper <= n_out_tamper;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_led_one = r_led_one;
    assign o_led_two = r_led_two;
    assign o_tone_on = r_tone;
    assign o_mode    = r_cur_mode;
    assign o_tamper  = r_out_tamper;

    // Checks on the controller state and the pipeline.
    `APC_ASSERT_IMPLIES(a_armed_silent, r_cur_mode == MODE_ARMED, !r_tone)
    `APC_ASSERT_IMPLIES(a_disarmed_no_trig,
        (r_cur_mode == MODE_DISARMED) && (r_prev_mode == MODE_DISARMED),
        !r_trig_one && !r_trig_two)
    `APC_ASSERT_IMPLIES(a_armed_count_range,
        (r_cur_mode == MODE_ARMED) && (r_prev_mode == MODE_ARMED), r_cnt_one < FULL_PERIOD)
    `APC_ASSERT_IMPLIES(a_alarm_count_range,
        (r_cur_mode == MODE_ALARM) && (r_prev_mode == MODE_ALARM),
        (r_cnt_one < ALARM_PERIOD) && (r_cnt_two < ALARM_PERIOD))
    `APC_ASSERT_NEXT(a_word_reaches_output, r_in_valid && w_out_adv, r_out_valid)

endmodule
